[rtl/fsub_pkg.sv]
// Package for the first substring match block: stream field widths, op codes
// and the control bundle that the top level hands to every comparison cell.
// No dependencies.
package fsub_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAT_IDX_W   = 7;
    localparam int CFG_W       = 8;
    localparam int POS_FIELD_W = 16;
    localparam int IN_TDATA_W  = 16;   // data_byte, pattern_index, padding
    localparam int OUT_TDATA_W = 24;   // found, position, padding

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    typedef struct packed {
        logic                  text_step;  // a text byte is accepted this cycle
        logic                  clear;      // search ends: empty the text window
        logic                  pat_we;     // pattern byte write
        logic [PAT_IDX_W-1:0]  pat_index;
        logic [BYTE_W-1:0]     data;
    } t_cell_ctrl;

endpackage

[rtl/fsub_cell.sv]
// One cell of the match chain: holds pattern byte CELL_INDEX and text window
// slot CELL_INDEX, and compares the byte shifting in with its lined-up pattern byte.
// Depends on fsub_pkg.
module fsub_cell
    import fsub_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [BYTE_W-1:0] i_prev_byte,   // window byte of the cell before, new byte at the head
    input  logic [BYTE_W-1:0] i_cmp_byte,    // pattern byte lined up with this window slot
    output logic [BYTE_W-1:0] o_byte,
    output logic [BYTE_W-1:0] o_pattern,
    output logic              o_equal
);

    logic [BYTE_W-1:0] r_pattern;
    logic [BYTE_W-1:0] r_window;
    logic [BYTE_W-1:0] n_window;

    always_comb begin
        n_window = i_prev_byte;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pat_we && (32'(i_ctrl.pat_index) == CELL_INDEX)) begin
            r_pattern <= i_ctrl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (i_ctrl.text_step) begin
            // a search that ends starts the next one with an empty window
            r_window <= i_ctrl.clear ? '0 : n_window;
        end
    end

    assign o_byte    = r_window;
    assign o_pattern = r_pattern;
    assign o_equal   = (n_window == i_cmp_byte);

endmodule

[rtl/first_substring_match.sv]
// Top level of the first substring match block: config register, search
// counters, output register and the chain of fsub_cell comparison cells.
// Depends on fsub_pkg and fsub_cell.
//
// Usage: write pattern_length on the cfg channel while the block is idle. Send
// pattern bytes on the slave stream with tuser = 0 (tdata holds byte and slot),
// then text bytes with tuser = 1, tlast high on the final byte of a search.
// Each cell holds one pattern byte and one slot of the text window; every text
// byte shifts the window one cell along and each cell compares the byte moving
// in with the pattern byte lined up for the current length, so the whole window
// is checked in the cycle the byte is taken; one item per cycle while not stalled.
// A result (found, position) is on the master stream in the cycle after the
// text byte that causes it: the first full match, or a not-found result on the
// last byte of a search without a match. At most one result per search.
// Throughput is one item per cycle while the master side takes results; the
// single output register stalls the slave side only while a result waits and
// the receiver holds tready low. Reset empties the output register, sets
// pattern_length to 1 and clears the text window and the byte count; the
// pattern bytes are undefined until written. After the last byte the search
// state is clear from the next cycle on.
module first_substring_match
    import fsub_pkg::*;
#(
    parameter int PATTERN_MAX   = 128,
    parameter int POSITION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,      // pattern_length
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,       // data_byte[7:0], pattern_index[14:8]
    input  logic                   i_s_tlast,
    input  logic [0:0]             i_s_tuser,       // op
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata        // found[0], position[16:1]
);

    localparam int IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SHIFT_W = IDX_W + 4;
    localparam int LANE_W  = PATTERN_MAX * BYTE_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [CFG_W-1:0]         r_pattern_length;
    logic [POSITION_BITS-1:0] r_count;
    logic                     r_overflow;
    logic                     r_reported;
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [POS_FIELD_W-1:0]   r_out_pos;

    logic                     accept;
    logic                     text_acc;
    logic [CFG_W-1:0]         eff_len;
    logic [IDX_W-1:0]         shift_lanes;
    logic [POSITION_BITS-1:0] n_count;
    logic                     n_overflow;
    logic [POSITION_BITS-1:0] hit_pos;
    logic [31:0]              hit_pos32;
    logic                     hit;
    logic                     miss;
    logic                     win_match;
    t_cell_ctrl               ctrl;
    logic [LANE_W-1:0]        window_bytes;
    logic [LANE_W-1:0]        rev_pat;
    logic [LANE_W-1:0]        aligned_pat;
    logic [PATTERN_MAX-1:0]   lane_eq;
    logic [PATTERN_MAX-1:0]   lane_used;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign text_acc    = accept && (i_s_tuser[0] == OP_TEXT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_pattern_length <= i_cfg_data;
        end
    end

    // clamp the length into 1..PATTERN_MAX
    always_comb begin
        if (r_pattern_length == '0) begin
            eff_len = CFG_W'(1);
        end else if (32'(r_pattern_length) > PATTERN_MAX) begin
            eff_len = CFG_W'(PATTERN_MAX);
        end else begin
            eff_len = r_pattern_length;
        end
    end

    // pattern bytes sit in reverse order; shifting them down by PATTERN_MAX - length
    // lines pattern byte length-1-j up with window slot j
    always_comb begin
        shift_lanes = IDX_W'(PATTERN_MAX) - IDX_W'(eff_len);
        aligned_pat = rev_pat >> (SHIFT_W'(shift_lanes) * SHIFT_W'(BYTE_W));
        lane_used   = {PATTERN_MAX{1'b1}} >> shift_lanes;
        win_match   = &(lane_eq | ~lane_used);
    end

    always_comb begin
        ctrl.text_step = text_acc;
        ctrl.clear     = i_s_tlast;
        ctrl.pat_we    = accept && (i_s_tuser[0] == OP_PATTERN);
        ctrl.pat_index = i_s_tdata[BYTE_W +: PAT_IDX_W];
        ctrl.data      = i_s_tdata[BYTE_W-1:0];
    end

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [BYTE_W-1:0] prev_byte;
        if (k == 0) begin : g_head
            assign prev_byte = ctrl.data;
        end else begin : g_body
            assign prev_byte = window_bytes[(k-1)*BYTE_W +: BYTE_W];
        end
        fsub_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_prev_byte (prev_byte),
            .i_cmp_byte  (aligned_pat[k*BYTE_W +: BYTE_W]),
            .o_byte      (window_bytes[k*BYTE_W +: BYTE_W]),
            .o_pattern   (rev_pat[(PATTERN_MAX-1-k)*BYTE_W +: BYTE_W]),
            .o_equal     (lane_eq[k])
        );
    end

    always_comb begin
        // hold the count at its maximum and remember that it got there
        n_overflow = r_overflow || (r_count == POS_MAX);
        n_count    = (r_count == POS_MAX) ? r_count : r_count + POSITION_BITS'(1);
        hit        = !r_reported && (n_count >= POSITION_BITS'(eff_len)) && win_match;
        miss       = !r_reported && !hit && i_s_tlast;
        hit_pos    = n_overflow ? POS_MAX
                                : n_count - POSITION_BITS'(eff_len) + POSITION_BITS'(1);
        hit_pos32  = 32'(hit_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_reported <= 1'b0;
        end else if (text_acc) begin
            if (i_s_tlast) begin
                r_count    <= '0;
                r_overflow <= 1'b0;
                r_reported <= 1'b0;
            end else begin
                r_count    <= n_count;
                r_overflow <= n_overflow;
                r_reported <= r_reported || hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= text_acc && (hit || miss);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && text_acc) begin
            r_out_found <= hit;
            r_out_pos   <= hit ? hit_pos32[POS_FIELD_W-1:0] : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - POS_FIELD_W - 1)'(0), r_out_pos, r_out_found};

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_out_valid)
        else $error("input stalled with no result waiting");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        text_acc && i_s_tlast |=> (r_count == '0) && !r_reported && !r_overflow)
        else $error("search state not cleared after last byte");

    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == POS_MAX))
        else $error("overflow set while count below maximum");

    a_reported_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reported |-> (r_count != '0))
        else $error("match reported with no text bytes counted");

endmodule
